// File: design/tfn_pkg.sv
`timescale 1ns / 1ps
// tfn_pkg: widths, constants and shared types of the triangle face normal core
// no dependencies; imported by tfn_sqrt, tfn_div and triangle_face_normal_core
package tfn_pkg;
	localparam int VW      = 24;   // vertex coordinate width
	localparam int EW      = 25;   // edge vector width
	localparam int PW      = 50;   // signed edge product width
	localparam int CW      = 51;   // signed cross product width
	localparam int MW      = 49;   // cross magnitude width
	localparam int HW      = 24;   // high half of a magnitude
	localparam int LOW     = 25;   // low half of a magnitude
	localparam int SQW     = 98;   // square of a magnitude
	localparam int SW      = 100;  // sum of squares
	localparam int RW      = 102;  // square root remainder and trial width
	localparam int LENW    = 50;   // length (integer square root) width
	localparam int QW      = 15;   // quotient width, holds 16384
	localparam int OW      = 16;   // output component width
	localparam int ONE_Q14 = 16384;

	typedef struct packed {
		logic [2:0][MW-1:0] mag;
		logic [2:0]         neg;
		logic               degen;
	} side_t;
endpackage

// File: design/tfn_sqrt.sv
`timescale 1ns / 1ps
// tfn_sqrt: pipelined restoring integer square root, one result bit per stage
// depends on tfn_pkg
module tfn_sqrt import tfn_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_vld,
	input  logic [SW-1:0]   in_sum,
	input  side_t           in_side,
	output logic            out_vld,
	output logic [LENW-1:0] out_len,
	output side_t           out_side
);
	logic            vld_s  [LENW];
	logic [RW-1:0]   rem_s  [LENW];
	logic [LENW-1:0] root_s [LENW];
	side_t           side_s [LENW];

	for (genvar k = 0; k < LENW; k++) begin : g_step
		localparam int B = LENW - 1 - k;
		logic            pv;
		logic [RW-1:0]   prem;
		logic [LENW-1:0] proot;
		side_t           pside;
		logic [RW-1:0]   trial;

		if (k == 0) begin : g_first
			assign pv    = in_vld;
			assign prem  = RW'(in_sum);
			assign proot = '0;
			assign pside = in_side;
		end else begin : g_next
			assign pv    = vld_s[k-1];
			assign prem  = rem_s[k-1];
			assign proot = root_s[k-1];
			assign pside = side_s[k-1];
		end

		// (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
		assign trial = (RW'(proot) << (B + 1)) | (RW'(1) << (2 * B));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			side_s[k] <= pside;
			if (trial <= prem) begin
				rem_s[k]  <= prem - trial;
				root_s[k] <= proot | (LENW'(1) << B);
			end else begin
				rem_s[k]  <= prem;
				root_s[k] <= proot;
			end
		end
	end

	assign out_vld  = vld_s[LENW-1];
	assign out_len  = root_s[LENW-1];
	assign out_side = side_s[LENW-1];
endmodule

// File: design/tfn_div.sv
`timescale 1ns / 1ps
// tfn_div: three parallel pipelined restoring dividers, mag*2^14 / len
// depends on tfn_pkg; expects mag <= len so the quotient fits in QW bits
module tfn_div import tfn_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_vld,
	input  logic [LENW-1:0]     in_len,
	input  side_t               in_side,
	output logic                out_vld,
	output logic [2:0][QW-1:0]  out_quo,
	output side_t               out_side
);
	logic                   vld_s  [QW];
	logic [LENW-1:0]        len_s  [QW];
	logic [2:0][LENW-1:0]   rem_s  [QW];
	logic [2:0][QW-1:0]     quo_s  [QW];
	side_t                  side_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_step
		localparam int B = QW - 1 - k;
		logic                 pv;
		logic [LENW-1:0]      plen;
		logic [2:0][LENW:0]   ptry;
		logic [2:0][QW-1:0]   pquo;
		side_t                pside;

		if (k == 0) begin : g_first
			assign pv    = in_vld;
			assign plen  = in_len;
			assign pside = in_side;
			assign pquo  = '0;
			for (genvar i = 0; i < 3; i++) begin : g_c
				assign ptry[i] = (LENW + 1)'(in_side.mag[i]);
			end
		end else begin : g_next
			assign pv    = vld_s[k-1];
			assign plen  = len_s[k-1];
			assign pside = side_s[k-1];
			assign pquo  = quo_s[k-1];
			for (genvar i = 0; i < 3; i++) begin : g_c
				assign ptry[i] = {rem_s[k-1][i], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			logic [LENW:0] diff;
			len_s[k]  <= plen;
			side_s[k] <= pside;
			for (int i = 0; i < 3; i++) begin
				diff = ptry[i] - {1'b0, plen};
				if (ptry[i] >= {1'b0, plen}) begin
					rem_s[k][i] <= diff[LENW-1:0];
					quo_s[k][i] <= pquo[i] | (QW'(1) << B);
				end else begin
					rem_s[k][i] <= ptry[i][LENW-1:0];
					quo_s[k][i] <= pquo[i];
				end
			end
		end
	end

	assign out_vld  = vld_s[QW-1];
	assign out_quo  = quo_s[QW-1];
	assign out_side = side_s[QW-1];
endmodule

// File: design/triangle_face_normal_core.sv
`timescale 1ns / 1ps
// triangle_face_normal_core: unit flat-shading normal of one triangle per cycle
// datapath from the accepting edge to the done cycle: 7 front stages
// (edges, products, cross, magnitude, partial squares, squares, sum), 50 square
// root stages, 15 divide stages, 1 output stage; throughput one request per cycle
// busy is always low, results cannot be held off; arst_n clears all valid bits
// depends on tfn_pkg, tfn_sqrt, tfn_div
module triangle_face_normal_core import tfn_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic signed [VW-1:0] a_x,
	input  logic signed [VW-1:0] a_y,
	input  logic signed [VW-1:0] a_z,
	input  logic signed [VW-1:0] b_x,
	input  logic signed [VW-1:0] b_y,
	input  logic signed [VW-1:0] b_z,
	input  logic signed [VW-1:0] c_x,
	input  logic signed [VW-1:0] c_y,
	input  logic signed [VW-1:0] c_z,
	output logic                 done,
	output logic signed [OW-1:0] norm_x,
	output logic signed [OW-1:0] norm_y,
	output logic signed [OW-1:0] norm_z,
	output logic                 degenerate
);
	// the pipeline never stalls, so a request is always taken
	assign busy = 1'b0;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	// stage 1: edge vectors e1 = c - a, e2 = b - a
	logic signed [EW-1:0] e1_s1 [3];
	logic signed [EW-1:0] e2_s1 [3];
	// stage 2: the edge products of the cross product
	logic signed [PW-1:0] p_s2 [6];
	// stage 3: cross product components
	logic signed [CW-1:0] cr_s3 [3];
	// stage 4 onward: magnitudes, signs and zero flag travel as side data
	side_t side_s4, side_s5, side_s6, side_s7;
	// stage 5: partial products of each square (magnitude split in two halves)
	logic [2*HW-1:0]      hh_s5 [3];
	logic [HW+LOW-1:0]    hl_s5 [3];
	logic [2*LOW-1:0]     ll_s5 [3];
	// stage 6: squares
	logic [SQW-1:0]       sq_s6 [3];
	// stage 7: sum of squares
	logic [SW-1:0]        sum_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s1 <= start & ~busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// front datapath, no reset on payload
	always_ff @(posedge clk) begin
		logic signed [CW-1:0] absv;
		// edges, sign extended by one bit so the difference cannot wrap
		e1_s1[0] <= EW'(c_x) - EW'(a_x);
		e1_s1[1] <= EW'(c_y) - EW'(a_y);
		e1_s1[2] <= EW'(c_z) - EW'(a_z);
		e2_s1[0] <= EW'(b_x) - EW'(a_x);
		e2_s1[1] <= EW'(b_y) - EW'(a_y);
		e2_s1[2] <= EW'(b_z) - EW'(a_z);

		// n = cross(e1, e2)
		p_s2[0] <= e1_s1[1] * e2_s1[2];
		p_s2[1] <= e1_s1[2] * e2_s1[1];
		p_s2[2] <= e1_s1[2] * e2_s1[0];
		p_s2[3] <= e1_s1[0] * e2_s1[2];
		p_s2[4] <= e1_s1[0] * e2_s1[1];
		p_s2[5] <= e1_s1[1] * e2_s1[0];

		cr_s3[0] <= CW'(p_s2[0]) - CW'(p_s2[1]);
		cr_s3[1] <= CW'(p_s2[2]) - CW'(p_s2[3]);
		cr_s3[2] <= CW'(p_s2[4]) - CW'(p_s2[5]);

		// magnitude below 2^49, sign kept for the end
		for (int i = 0; i < 3; i++) begin
			absv = cr_s3[i][CW-1] ? -cr_s3[i] : cr_s3[i];
			side_s4.mag[i] <= absv[MW-1:0];
			side_s4.neg[i] <= cr_s3[i][CW-1];
		end
		side_s4.degen <= (cr_s3[0] == '0) && (cr_s3[1] == '0) && (cr_s3[2] == '0);

		// m^2 = hh*2^50 + hl*2^26 + ll with m = h*2^25 + l
		for (int i = 0; i < 3; i++) begin
			hh_s5[i] <= side_s4.mag[i][MW-1:LOW] * side_s4.mag[i][MW-1:LOW];
			hl_s5[i] <= side_s4.mag[i][MW-1:LOW] * side_s4.mag[i][LOW-1:0];
			ll_s5[i] <= side_s4.mag[i][LOW-1:0] * side_s4.mag[i][LOW-1:0];
		end
		side_s5 <= side_s4;

		for (int i = 0; i < 3; i++) begin
			sq_s6[i] <= (SQW'(hh_s5[i]) << (2 * LOW)) + (SQW'(hl_s5[i]) << (LOW + 1))
				+ SQW'(ll_s5[i]);
		end
		side_s6 <= side_s5;

		sum_s7  <= SW'(sq_s6[0]) + SW'(sq_s6[1]) + SW'(sq_s6[2]);
		side_s7 <= side_s6;
	end

	// length = floor(sqrt(sum))
	logic            sq_vld;
	logic [LENW-1:0] sq_len;
	side_t           sq_side;

	tfn_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (v_s7),
		.in_sum   (sum_s7),
		.in_side  (side_s7),
		.out_vld  (sq_vld),
		.out_len  (sq_len),
		.out_side (sq_side)
	);

	// quotients mag*16384/len; len is zero only for a degenerate triangle,
	// whose quotients are discarded below
	logic               dv_vld;
	logic [2:0][QW-1:0] dv_quo;
	side_t              dv_side;

	tfn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (sq_vld),
		.in_len   (sq_len),
		.in_side  (sq_side),
		.out_vld  (dv_vld),
		.out_quo  (dv_quo),
		.out_side (dv_side)
	);

	// output stage: clamp to one, restore sign, zero a degenerate normal
	logic [2:0][OW-1:0] comp;

	always_comb begin
		logic [QW-1:0] qc;
		for (int i = 0; i < 3; i++) begin
			qc = (dv_quo[i] > QW'(ONE_Q14)) ? QW'(ONE_Q14) : dv_quo[i];
			if (dv_side.degen) begin
				comp[i] = '0;
			end else if (dv_side.neg[i]) begin
				comp[i] = -OW'(qc);
			end else begin
				comp[i] = OW'(qc);
			end
		end
	end

	logic          done_q;
	logic [OW-1:0] nx_q, ny_q, nz_q;
	logic          degen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		nx_q    <= comp[0];
		ny_q    <= comp[1];
		nz_q    <= comp[2];
		degen_q <= dv_side.degen;
	end

	assign done       = done_q;
	assign norm_x     = nx_q;
	assign norm_y     = ny_q;
	assign norm_z     = nz_q;
	assign degenerate = degen_q;
endmodule
